>>> hdl/bpa_pkg.sv
// Shared types, constants and helpers for the buddy page allocator.
// No dependencies; imported by every module of the block except bpa_ram.
package bpa_pkg;

  localparam int POOL_PAGES = 2048;
  localparam int NUM_ORDERS = 11;
  localparam int TOP_ORDER  = NUM_ORDERS - 1;
  localparam int PAGE_SHIFT = 12;                  // 4096-byte pages
  localparam int ADDR_W     = 48;
  localparam int CNT_W      = 12;                  // page_count / pool size
  localparam int IDX_W      = 11;                  // page / block index
  localparam int ORD_W      = 4;
  localparam int REC_W      = 5;                   // order + 1, 0 = none
  localparam int WORD_W     = 32;                  // free-map RAM word
  localparam int BIT_W      = 5;
  localparam int WSEL_W     = IDX_W - BIT_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 48;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE    = 1'd1;
  localparam logic [CNT_W-1:0]     TOTAL_RESET      = CNT_W'(POOL_PAGES);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_BLOCK = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // Which block bit the free-map port points at.
  typedef enum logic [1:0] {
    TG_SCAN   = 2'd0,   // word under scan
    TG_IDX    = 2'd1,   // current block
    TG_IDX_HI = 2'd2,   // upper half after a split
    TG_BUDDY  = 2'd3    // buddy of current block
  } tgt_e;

  function automatic int order_words(input int k);
    return ((POOL_PAGES >> k) > WORD_W) ? ((POOL_PAGES >> k) >> BIT_W) : 1;
  endfunction

  function automatic int fm_words();
    int acc;
    acc = 0;
    for (int j = 0; j < NUM_ORDERS; j++) acc += order_words(j);
    return acc;
  endfunction

  localparam int FM_WORDS = fm_words();
  localparam int FM_AW    = $clog2(FM_WORDS);

  // First free-map word of order k.
  function automatic logic [FM_AW-1:0] order_base(input logic [ORD_W-1:0] k);
    logic [FM_AW-1:0] acc;
    acc = '0;
    for (int j = 0; j < NUM_ORDERS; j++) begin
      if (ORD_W'(j) < k) acc = acc + FM_AW'(order_words(j));
    end
    return acc;
  endfunction

  function automatic logic [WSEL_W-1:0] order_last(input logic [ORD_W-1:0] k);
    logic [WSEL_W-1:0] r;
    r = '0;
    for (int j = 0; j < NUM_ORDERS; j++) begin
      if (ORD_W'(j) == k) r = WSEL_W'(order_words(j) - 1);
    end
    return r;
  endfunction

  typedef struct packed {
    logic    sweep;
    logic    latch;
    logic    scan_start;
    logic    scan_next_word;
    logic    scan_next_order;
    logic    hit;
    logic    fm_rd;
    logic    fm_wr;
    logic    fm_set;
    tgt_e    tgt;
    logic    split;
    logic    merge;
    logic    rec_rd;
    logic    rec_free;
    logic    rec_alloc;
    logic    resp;
    status_e resp_status;
    logic    resp_addr;
  } bpa_ctl_t;

  typedef struct packed {
    logic is_free;
    logic count_bad;
    logic addr_bad;
    logic word_hit;
    logic last_word;
    logic top_order;
    logic above_need;
    logic rec_zero;
    logic tgt_bit;
    logic sweep_last;
    logic rebuild;
  } bpa_sts_t;

endpackage

>>> hdl/buddy_page_allocator_core.sv
// Buddy page allocator core. Results: bad size or misaligned free, free of an
// unallocated page, no block after a scan of the free map (up to 131 free-map words),
// alloc after the word scan and any splits, free after any merges. One transaction at a
// time, paced by free-map read-modify-write; busy drops with the done_o strobe.
// Reset and every pool-size write made while idle run a rebuild sweep; the receiver
// cannot stall.
module buddy_page_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bpa_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd_i,
  input  logic [bpa_pkg::CNT_W-1:0]     page_count_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    address_i,
  output logic                          done_o,
  output logic [bpa_pkg::ADDR_W-1:0]    block_address_o,
  output logic [1:0]                    status_o
);
  import bpa_pkg::*;

  bpa_ctl_t ctl;   // sequencer -> datapath commands
  bpa_sts_t sts;   // datapath -> sequencer conditions

  // Sequencer: walks orders for search, split and merge.
  bpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // Datapath: free map (one word row per order chunk), allocation record,
  // address math and the result register.
  bpa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd_i),
    .page_count_i    (page_count_i),
    .address_i       (address_i),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .done_o          (done_o),
    .block_address_o (block_address_o),
    .status_o        (status_o)
  );

  // A transaction always ends in a single-cycle strobe.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe held two cycles");

  // An accepted transaction makes the block busy.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start accepted but not busy");

  // Failed or free results carry a zero address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (block_address_o == '0))
    else $error("nonzero address on failure");

  // Pool resize while idle starts the rebuild sweep.
  a_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == REG_POOL_SIZE && !busy) |=> busy)
    else $error("rebuild not started");

endmodule

>>> hdl/bpa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bpa_dp.sv
// Allocator datapath: config registers, free map and allocation record RAMs,
// order/index registers and the result register. Uses bpa_pkg, bpa_ram.
module bpa_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bpa_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             cmd_i,
  input  logic [bpa_pkg::CNT_W-1:0]        page_count_i,
  input  logic [bpa_pkg::ADDR_W-1:0]       address_i,
  input  bpa_pkg::bpa_ctl_t                ctl_i,
  output bpa_pkg::bpa_sts_t                sts_o,
  output logic                             done_o,
  output logic [bpa_pkg::ADDR_W-1:0]       block_address_o,
  output logic [1:0]                       status_o
);
  import bpa_pkg::*;

  logic [ADDR_W-1:0] base_q;
  logic [CNT_W-1:0]  total_q;
  logic [IDX_W-1:0]  cnt_q;
  logic              cmd_q;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] address_q;
  logic [ORD_W-1:0]  need_q, k_q;
  logic [WSEL_W-1:0] w_q;
  logic [IDX_W-1:0]  idx_q;
  logic              done_q;
  logic [ADDR_W-1:0] block_address_q;
  status_e           status_q;

  logic [CNT_W-1:0]  pages;
  logic [CNT_W-1:0]  cm1;
  logic [ORD_W-1:0]  need_c;
  logic [ADDR_W-1:0] off;
  logic [IDX_W-1:0]  page;
  logic [IDX_W-1:0]  alloc_page;
  logic [IDX_W-1:0]  tgt;
  logic [FM_AW-1:0]  fm_addr;
  logic [WORD_W-1:0] fm_rdata, fm_wdata, fm_mask, carve_word;
  logic [BIT_W-1:0]  ffs;
  logic              sweep_fm;
  logic [REC_W-1:0]  rec_rdata;
  logic [ORD_W-1:0]  rec_ord;

  // Clamp of pool size.
  assign pages = (total_q > TOTAL_RESET) ? TOTAL_RESET : total_q;

  // Order needed: bit length of count - 1.
  assign cm1 = count_q - CNT_W'(1);
  always_comb begin
    need_c = '0;
    for (int j = 0; j < CNT_W; j++) begin
      if (cm1[j]) need_c = ORD_W'(j + 1);
    end
  end

  assign off        = address_q - base_q;
  assign page       = off[PAGE_SHIFT +: IDX_W];
  assign alloc_page = idx_q << need_q;

  always_comb begin
    case (ctl_i.tgt)
      TG_SCAN:   tgt = {w_q, {BIT_W{1'b0}}};
      TG_IDX:    tgt = idx_q;
      TG_IDX_HI: tgt = idx_q | IDX_W'(1);
      TG_BUDDY:  tgt = idx_q ^ IDX_W'(1);
      default:   tgt = idx_q;
    endcase
  end

  assign fm_addr = order_base(k_q) + FM_AW'(tgt[IDX_W-1:BIT_W]);
  assign fm_mask = WORD_W'(1) << tgt[BIT_W-1:0];

  // Rebuild image of one free-map word: largest blocks first from the base.
  always_comb begin
    logic [IDX_W-1:0]  j;
    logic [FM_AW-1:0]  a;
    logic [FM_AW-1:0]  rel;
    carve_word = '0;
    a = cnt_q[FM_AW-1:0];
    for (int k = 0; k < NUM_ORDERS; k++) begin
      rel = a - order_base(ORD_W'(k));
      j   = IDX_W'((pages >> (k + 1)) << 1);
      if (a >= order_base(ORD_W'(k)) && rel < FM_AW'(order_words(k))) begin
        if (pages[CNT_W-1]) begin
          // full pool: both top-order blocks
          if (k == TOP_ORDER) carve_word[1:0] = 2'b11;
        end else if (pages[k] && FM_AW'(j[IDX_W-1:BIT_W]) == rel) begin
          carve_word[j[BIT_W-1:0]] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    ffs = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (fm_rdata[j]) ffs = BIT_W'(j);
    end
  end

  assign sweep_fm = ctl_i.sweep && (cnt_q < IDX_W'(FM_WORDS));
  assign fm_wdata = sweep_fm ? carve_word :
                    ctl_i.fm_set ? (fm_rdata | fm_mask) : (fm_rdata & ~fm_mask);

  bpa_ram #(.WIDTH(WORD_W), .DEPTH(FM_WORDS)) u_fm_ram (
    .clk_i   (clk_i),
    .we_i    (sweep_fm || ctl_i.fm_wr),
    .waddr_i (sweep_fm ? cnt_q[FM_AW-1:0] : fm_addr),
    .wdata_i (fm_wdata),
    .re_i    (ctl_i.fm_rd),
    .raddr_i (fm_addr),
    .rdata_o (fm_rdata)
  );

  bpa_ram #(.WIDTH(REC_W), .DEPTH(POOL_PAGES)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.sweep || ctl_i.rec_free || ctl_i.rec_alloc),
    .waddr_i (ctl_i.sweep ? cnt_q : (ctl_i.rec_free ? page : alloc_page)),
    .wdata_i (ctl_i.rec_alloc ? REC_W'(need_q) + REC_W'(1) : '0),
    .re_i    (ctl_i.rec_rd),
    .raddr_i (page),
    .rdata_o (rec_rdata)
  );

  assign rec_ord = ORD_W'(rec_rdata - REC_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      total_q <= TOTAL_RESET;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ctl_i.resp;
      if (cfg_we_i && cfg_idx_i == REG_BASE_ADDRESS) begin
        base_q <= cfg_wdata_i[ADDR_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == REG_POOL_SIZE) begin
        total_q <= cfg_wdata_i[CNT_W-1:0];
        cnt_q   <= '0;
      end else if (ctl_i.sweep) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q     <= cmd_i;
      count_q   <= page_count_i;
      address_q <= address_i;
    end
    if (ctl_i.scan_start) begin
      need_q <= need_c;
      k_q    <= need_c;
      w_q    <= '0;
    end else if (ctl_i.scan_next_order) begin
      k_q <= k_q + ORD_W'(1);
      w_q <= '0;
    end else if (ctl_i.scan_next_word) begin
      w_q <= w_q + WSEL_W'(1);
    end else if (ctl_i.hit) begin
      idx_q <= {w_q, ffs};
    end else if (ctl_i.split) begin
      k_q   <= k_q - ORD_W'(1);
      idx_q <= idx_q << 1;
    end else if (ctl_i.merge) begin
      k_q   <= k_q + ORD_W'(1);
      idx_q <= idx_q >> 1;
    end else if (ctl_i.rec_free) begin
      k_q   <= rec_ord;
      idx_q <= page >> rec_ord;
    end
    if (ctl_i.resp) begin
      status_q        <= ctl_i.resp_status;
      block_address_q <= ctl_i.resp_addr ?
          base_q + {{(ADDR_W-IDX_W-PAGE_SHIFT){1'b0}}, alloc_page, {PAGE_SHIFT{1'b0}}} :
          '0;
    end
  end

  assign sts_o.is_free    = (cmd_q == CMD_FREE);
  assign sts_o.count_bad  = (count_q == '0) || (count_q > CNT_W'(1 << TOP_ORDER));
  assign sts_o.addr_bad   = (off[PAGE_SHIFT-1:0] != '0) ||
                            (off[ADDR_W-1:PAGE_SHIFT+IDX_W] != '0);
  assign sts_o.word_hit   = (fm_rdata != '0);
  assign sts_o.last_word  = (w_q == order_last(k_q));
  assign sts_o.top_order  = (k_q == ORD_W'(TOP_ORDER));
  assign sts_o.above_need = (k_q > need_q);
  assign sts_o.rec_zero   = (rec_rdata == '0);
  assign sts_o.tgt_bit    = fm_rdata[tgt[BIT_W-1:0]];
  assign sts_o.sweep_last = (cnt_q == '1);
  assign sts_o.rebuild    = cfg_we_i && (cfg_idx_i == REG_POOL_SIZE);

  assign done_o          = done_q;
  assign block_address_o = block_address_q;
  assign status_o        = status_q;

endmodule

>>> hdl/bpa_ctrl.sv
// Allocator sequencer: one-hot state machine driving the datapath commands.
// Uses bpa_pkg.
module bpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bpa_pkg::bpa_sts_t sts_i,
  output bpa_pkg::bpa_ctl_t ctl_o
);
  import bpa_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR     = 14'b00000000000001,
    S_IDLE      = 14'b00000000000010,
    S_DECODE    = 14'b00000000000100,
    S_SCAN_RD   = 14'b00000000001000,
    S_SCAN_CHK  = 14'b00000000010000,
    S_TAKE      = 14'b00000000100000,
    S_SET_RD    = 14'b00000001000000,
    S_SET_WR    = 14'b00000010000000,
    S_REC_WR    = 14'b00000100000000,
    S_REC_CHK   = 14'b00001000000000,
    S_MERGE_TST = 14'b00010000000000,
    S_MERGE_CHK = 14'b00100000000000,
    S_SPARE_A   = 14'b01000000000000,
    S_SPARE_B   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_CLEAR: begin
        ctl_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (sts_i.rebuild) begin
          state_d = S_CLEAR;
        end else if (start) begin
          ctl_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.is_free) begin
          if (sts_i.count_bad) begin
            ctl_o.resp        = 1'b1;
            ctl_o.resp_status = ST_BAD_SIZE;
            state_d           = S_IDLE;
          end else begin
            ctl_o.scan_start = 1'b1;
            state_d          = S_SCAN_RD;
          end
        end else if (sts_i.addr_bad) begin
          ctl_o.resp        = 1'b1;
          ctl_o.resp_status = ST_BAD_FREE;
          state_d           = S_IDLE;
        end else begin
          ctl_o.rec_rd = 1'b1;
          state_d      = S_REC_CHK;
        end
      end
      S_SCAN_RD: begin
        ctl_o.fm_rd = 1'b1;
        ctl_o.tgt   = TG_SCAN;
        state_d     = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.word_hit) begin
          ctl_o.hit = 1'b1;
          state_d   = S_TAKE;
        end else if (sts_i.last_word) begin
          if (sts_i.top_order) begin
            ctl_o.resp        = 1'b1;
            ctl_o.resp_status = ST_NO_BLOCK;
            state_d           = S_IDLE;
          end else begin
            ctl_o.scan_next_order = 1'b1;
            state_d               = S_SCAN_RD;
          end
        end else begin
          ctl_o.scan_next_word = 1'b1;
          state_d              = S_SCAN_RD;
        end
      end
      S_TAKE: begin
        ctl_o.fm_wr = 1'b1;
        ctl_o.tgt   = TG_IDX;
        if (sts_i.above_need) begin
          ctl_o.split = 1'b1;
          state_d     = S_SET_RD;
        end else begin
          state_d = S_REC_WR;
        end
      end
      S_SET_RD: begin
        ctl_o.fm_rd = 1'b1;
        ctl_o.tgt   = sts_i.is_free ? TG_IDX : TG_IDX_HI;
        state_d     = S_SET_WR;
      end
      S_SET_WR: begin
        ctl_o.fm_wr  = 1'b1;
        ctl_o.fm_set = 1'b1;
        ctl_o.tgt    = sts_i.is_free ? TG_IDX : TG_IDX_HI;
        if (sts_i.is_free) begin
          ctl_o.resp        = 1'b1;
          ctl_o.resp_status = ST_OK;
          state_d           = S_IDLE;
        end else if (sts_i.above_need) begin
          ctl_o.split = 1'b1;
          state_d     = S_SET_RD;
        end else begin
          state_d = S_REC_WR;
        end
      end
      S_REC_WR: begin
        ctl_o.rec_alloc   = 1'b1;
        ctl_o.resp        = 1'b1;
        ctl_o.resp_status = ST_OK;
        ctl_o.resp_addr   = 1'b1;
        state_d           = S_IDLE;
      end
      S_REC_CHK: begin
        if (sts_i.rec_zero) begin
          ctl_o.resp        = 1'b1;
          ctl_o.resp_status = ST_BAD_FREE;
          state_d           = S_IDLE;
        end else begin
          ctl_o.rec_free = 1'b1;
          state_d        = S_MERGE_TST;
        end
      end
      S_MERGE_TST: begin
        if (sts_i.top_order) begin
          state_d = S_SET_RD;
        end else begin
          ctl_o.fm_rd = 1'b1;
          ctl_o.tgt   = TG_BUDDY;
          state_d     = S_MERGE_CHK;
        end
      end
      S_MERGE_CHK: begin
        ctl_o.tgt = TG_BUDDY;
        if (sts_i.tgt_bit) begin
          ctl_o.fm_wr = 1'b1;
          ctl_o.merge = 1'b1;
          state_d     = S_MERGE_TST;
        end else begin
          state_d = S_SET_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> test/buddy_page_allocator_core_checker.sv
`timescale 1ns / 100ps
// Checker for the buddy page allocator: tracks config writes, predicts each
// transaction's result from its own free map, compares the done_o strobes.
// Depends on bpa_pkg.
module buddy_page_allocator_core_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bpa_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          cmd_i,
  input  logic [bpa_pkg::CNT_W-1:0]     page_count_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    address_i,
  input  logic                          done_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    block_address_i,
  input  logic [1:0]                    status_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import bpa_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_e           status;
  } alloc_result_t;

  logic [ADDR_W-1:0] pool_base;
  logic [CNT_W-1:0]  pool_pages;
  bit                free_bits [NUM_ORDERS][POOL_PAGES];
  logic [REC_W-1:0]  block_rec [POOL_PAGES];
  alloc_result_t     expected_results[$];

  function automatic void carve_pool();
    int pages, pos;
    pages = (pool_pages > POOL_PAGES) ? POOL_PAGES : pool_pages;
    pos   = 0;
    for (int k = 0; k < NUM_ORDERS; k++)
      for (int i = 0; i < POOL_PAGES; i++) free_bits[k][i] = 0;
    for (int i = 0; i < POOL_PAGES; i++) block_rec[i] = '0;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      while (pages - pos >= (1 << k)) begin
        free_bits[k][pos >> k] = 1;
        pos += 1 << k;
      end
    end
  endfunction

  function automatic alloc_result_t alloc_block(input logic [CNT_W-1:0] count);
    alloc_result_t r;
    int need, k, idx;
    bit hit;
    r.addr = '0;
    need = 0;
    hit = 0;
    idx = 0;
    if (count == 0 || count > (1 << TOP_ORDER)) begin
      r.status = ST_BAD_SIZE;
      return r;
    end
    while ((1 << need) < count) need++;
    for (k = need; k <= TOP_ORDER; k++) begin
      for (int i = 0; i < (POOL_PAGES >> k); i++)
        if (free_bits[k][i]) begin
          idx = i;
          hit = 1;
          break;
        end
      if (hit) break;
    end
    if (!hit) begin
      r.status = ST_NO_BLOCK;
      return r;
    end
    free_bits[k][idx] = 0;
    // split down, upper halves go back on the free map
    while (k > need) begin
      k--;
      idx = idx << 1;
      free_bits[k][idx + 1] = 1;
    end
    block_rec[idx << need] = REC_W'(need + 1);
    r.addr   = pool_base + (ADDR_W'(idx << need) << PAGE_SHIFT);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic status_e release_block(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] off;
    int page, k, idx;
    off = addr - pool_base;
    if (off[PAGE_SHIFT-1:0] != 0) return ST_BAD_FREE;
    if ((off >> PAGE_SHIFT) >= POOL_PAGES) return ST_BAD_FREE;
    page = int'(off >> PAGE_SHIFT);
    if (block_rec[page] == 0) return ST_BAD_FREE;
    k = block_rec[page] - 1;
    block_rec[page] = '0;
    idx = page >> k;
    while (k < TOP_ORDER) begin
      if ((idx ^ 1) >= (POOL_PAGES >> k) || !free_bits[k][idx ^ 1]) break;
      free_bits[k][idx ^ 1] = 0;
      idx = idx >> 1;
      k++;
    end
    free_bits[k][idx] = 1;
    return ST_OK;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t exp_r;
    if (!rst_ni) begin
      pool_base  = '0;
      pool_pages = TOTAL_RESET;
      carve_pool();
      expected_results.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_BASE_ADDRESS) pool_base = cfg_wdata_i;
        else if (cfg_idx_i == REG_POOL_SIZE) begin
          pool_pages = cfg_wdata_i[CNT_W-1:0];
          carve_pool();
        end
      end
      if (done_i) begin
        if (expected_results.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected result addr=%h status=%0d", $time,
                     block_address_i, status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.addr !== block_address_i || exp_r.status !== status_i) begin
            if (fail_count_o < 10)
              $display("%0t: mismatch exp addr=%h status=%0d got addr=%h status=%0d",
                       $time, exp_r.addr, exp_r.status, block_address_i, status_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (cmd_e'(cmd_i) == CMD_ALLOC) exp_r = alloc_block(page_count_i);
        else begin
          exp_r.addr   = '0;
          exp_r.status = release_block(address_i);
        end
        expected_results.push_back(exp_r);
      end
    end
    pending_o <= expected_results.size();
  end

endmodule

>>> test/buddy_page_allocator_core_test.sv
`timescale 1ns / 100ps
// Top of the buddy page allocator test: clock, reset, stimulus and verdict.
// Depends on bpa_pkg, buddy_page_allocator_core and the checker module.
module buddy_page_allocator_core_test;
  import bpa_pkg::*;

  localparam int STALL_LIMIT = 20000;  // outlasts the rebuild sweep
  localparam int PHASES      = 6;

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_BASE_ADDRESS;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 start = 0;
  logic                 busy;
  logic                 cmd_i = CMD_ALLOC;
  logic [CNT_W-1:0]     page_count_i = '0;
  logic [ADDR_W-1:0]    address_i = '0;
  logic                 done_o;
  logic [ADDR_W-1:0]    block_address_o;
  logic [1:0]           status_o;
  int                   fail_count, pending;

  // granted block addresses, fed from the result strobes; used to build frees
  logic [ADDR_W-1:0] live_blocks[$];
  logic [ADDR_W-1:0] last_freed;
  cmd_e              cmd_order[$];
  int                idle_mode;   // 0: no gaps, 1: random gaps
  int                stall_cycles = 0;

  buddy_page_allocator_core dut (.*);

  buddy_page_allocator_core_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .start_i(start), .busy_i(busy), .cmd_i, .page_count_i, .address_i,
    .done_i(done_o), .block_address_i(block_address_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // track which granted addresses are live, for realistic frees
  always @(posedge clk_i) begin
    cmd_e c;
    if (start && !busy) cmd_order.push_back(cmd_e'(cmd_i));
    if (done_o && cmd_order.size() != 0) begin
      c = cmd_order.pop_front();
      if (c == CMD_ALLOC && status_e'(status_o) == ST_OK)
        live_blocks.push_back(block_address_o);
    end
  end

  // watchdog: cycles without any accepted transaction or result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("buddy_page_allocator_core test failed");
      $finish;
    end
  end

  // Called at a clock edge; returns at the edge that accepts the transaction.
  // A zero gap keeps start high, so no low/high pair lands in one step.
  task automatic issue(input cmd_e c, input logic [CNT_W-1:0] cnt,
                       input logic [ADDR_W-1:0] addr);
    int gap;
    gap = (idle_mode == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1;
    cmd_i        <= c;
    page_count_i <= cnt;
    address_i    <= addr;
    do @(posedge clk_i); while (busy);
  endtask

  // sender holds off until the block has drained and gone idle; the first
  // edge lets pending and busy reflect the last accepted transaction
  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    repeat (2) @(posedge clk_i);
  endtask

  task automatic free_live();
    int pick;
    logic [ADDR_W-1:0] a;
    if (live_blocks.size() == 0) begin
      issue(CMD_FREE, CNT_W'($urandom), ADDR_W'({$urandom, $urandom}));
      return;
    end
    pick = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[pick];
    live_blocks.delete(pick);
    last_freed = a;
    issue(CMD_FREE, CNT_W'($urandom), a);
  endtask

  task automatic random_item();
    int r;
    logic [CNT_W-1:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      r = $urandom_range(0, 99);
      if (r < 60) cnt = CNT_W'($urandom_range(1, 4));
      else if (r < 85) cnt = CNT_W'($urandom_range(1, 64));
      else if (r < 95) cnt = CNT_W'($urandom_range(1, POOL_PAGES));
      else cnt = CNT_W'($urandom);
      issue(CMD_ALLOC, cnt, ADDR_W'({$urandom, $urandom}));
    end else if (r < 90) begin
      free_live();
    end else begin
      // noise: wild address, off-by-a-bit live address, double free
      r = $urandom_range(0, 2);
      if (r == 0)
        issue(CMD_FREE, '0, ADDR_W'({$urandom, $urandom}));
      else if (r == 1 && live_blocks.size() != 0)
        issue(CMD_FREE, '0, live_blocks[0] ^ (ADDR_W'(1) << $urandom_range(0, 47)));
      else
        issue(CMD_FREE, '0, last_freed);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] base_set [PHASES];
    logic [CNT_W-1:0]  pages_set[PHASES];
    last_freed   = '0;
    idle_mode    = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: size limits, whole pool, exhaustion, bad frees, reuse
    idle_mode = 0;
    issue(CMD_ALLOC, '0, '0);
    issue(CMD_ALLOC, 12'hFFF, '0);
    issue(CMD_ALLOC, 12'd2049, '0);
    issue(CMD_ALLOC, 12'd2048, '0);
    issue(CMD_ALLOC, 12'd1, '0);
    issue(CMD_FREE, '0, 48'd1);
    issue(CMD_FREE, '0, 48'd2048 << PAGE_SHIFT);
    issue(CMD_FREE, '0, 48'hFFFF_FFFF_F000);
    issue(CMD_FREE, '0, '0);
    issue(CMD_FREE, '0, '0);
    idle_mode = 1;
    issue(CMD_ALLOC, 12'd3, '0);
    issue(CMD_ALLOC, 12'd1, '0);
    issue(CMD_ALLOC, 12'd1, '0);
    issue(CMD_ALLOC, 12'd1024, '0);
    issue(CMD_ALLOC, 12'd1024, '0);
    issue(CMD_ALLOC, 12'd5, '0);
    drain();
    repeat (6) free_live();
    issue(CMD_FREE, '0, 48'h0000_0000_4000);
    drain();

    // config phases, extremes included; live list is stale after each write
    base_set[0] = 48'hFFFF_FF80_0000; pages_set[0] = 12'hFFF;
    base_set[1] = ADDR_W'({$urandom, $urandom});
    pages_set[1] = CNT_W'($urandom_range(1, 2047));
    base_set[2] = '0;                 pages_set[2] = 12'd0;
    base_set[3] = 48'hFFFF_FFFF_FFFF; pages_set[3] = 12'd1;
    base_set[4] = 48'h0000_0080_0000; pages_set[4] = 12'd2047;
    base_set[5] = '0;                 pages_set[5] = 12'd2048;
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_BASE_ADDRESS, base_set[p]);
      write_reg(REG_POOL_SIZE, CFG_W'(pages_set[p]));
      live_blocks.delete();
      last_freed = base_set[p];
      for (int n = 0; n < ((p == 2) ? 20 : 76); n++) begin
        if (n % 25 == 0) idle_mode = $urandom_range(0, 1);
        random_item();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("buddy_page_allocator_core test passed");
    else
      $display("buddy_page_allocator_core test failed");
    $finish;
  end

endmodule
